// File: src/stbs_pkg.sv
// Shared constants and types for the sorted-table binary search unit.
// Depends on nothing; imported by the top level and stbs_seq, not by stbs_ram.
`default_nettype none

package stbs_pkg;

    // Default geometry of the table
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_ENTRY_WIDTH = 32;

    // Fixed port widths
    localparam int INDEX_W = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;
    localparam int POS_W   = 8;

    // Item opcodes carried on the mode field
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    // Sequencer status toward the top level
    typedef struct packed {
        logic             idle;
        logic             done;
        logic             found;
        logic [POS_W-1:0] position;
    } stbs_stat_t;

endpackage

`default_nettype wire

// File: src/sorted_table_binary_search_unit.sv
// Top level of the sorted-table binary search unit: ports, count register, result register.
// Depends on stbs_pkg, stbs_ram and stbs_seq.
//
// Software loads the table in ascending unsigned order with write beats (mode 0), sets
// entries_in_use through the configuration port, then sends search beats (mode 1). A write
// beat leaves the input side open and gives no result. Each probe is one read of the
// single-read-port table RAM, whose read is registered (state S_PROBE), and one compare
// (state S_CMP). A search makes P probes (at most ceil(log2(n+1)), 9 for 256 entries, none
// for an empty table); the input side stays closed from the search beat until its result
// is taken into the output register, a load held off while an earlier result waits there.
// The result beat carries found and position (0 on a miss) and waits in that output
// register, so the next beat can be accepted before the result is taken. The table is not
// cleared by reset; probing an entry never written gives an undefined answer.
`default_nettype none

module sorted_table_binary_search_unit
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [COUNT_W-1:0] cfg_wr_data,
    // input beats
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic [INDEX_W-1:0] entry_index,
    input  wire logic [VALUE_W-1:0] value,
    // result beats
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    found,
    output logic      [POS_W-1:0]   position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0]     entries_in_use_reg;
    logic                   out_valid_reg;
    logic                   found_reg;
    logic [POS_W-1:0]       position_reg;

    stbs_stat_t             stat;
    logic                   in_fire;
    logic                   start;
    logic                   take;
    logic [63:0]            value_ext;
    logic [ENTRY_WIDTH-1:0] entry_val;
    logic [31:0]            index_ext;
    logic [31:0]            count_ext;
    logic [CW-1:0]          limit;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    // Decode the accepted beat
    always_comb
    begin
        in_ready  = stat.idle;
        in_fire   = in_valid && in_ready;
        value_ext = 64'(value);
        entry_val = value_ext[ENTRY_WIDTH-1:0];
        index_ext = 32'(entry_index);
        count_ext = 32'(entries_in_use_reg);
        ram_waddr = index_ext[AW-1:0];
        ram_we    = in_fire && (mode == MODE_WRITE) && (index_ext < TABLE_DEPTH);
        start     = in_fire && (mode == MODE_SEARCH);
        limit     = (count_ext > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : count_ext[CW-1:0];
        take      = stat.done && (!out_valid_reg || out_ready);
    end

    // Hold the entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            entries_in_use_reg <= cfg_wr_data;
        end
    end

    // Track the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            found_reg    <= stat.found;
            position_reg <= stat.position;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    stbs_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (entry_val),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    stbs_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .key     (entry_val),
        .limit   (limit),
        .take    (take),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .stat    (stat)
    );

    // A search beat closes the input side on the next cycle
    a_search_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode == MODE_SEARCH |=> !in_ready)
        else $error("input open during a search");

    // Table writes never overlap a probe read
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("table write during a probe");

endmodule

`default_nettype wire

// File: src/stbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Store one word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read word
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/stbs_seq.sv
// Probe sequencer: walks the halving range over the table RAM, a read state then a compare state per probe.
// Depends on stbs_pkg; drives the read port of stbs_ram.
`default_nettype none

module stbs_seq
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [ENTRY_WIDTH-1:0] key,
    input  wire logic [CW-1:0]          limit,
    input  wire logic                   take,
    output logic                        rd_en,
    output logic      [AW-1:0]          rd_addr,
    input  wire logic [ENTRY_WIDTH-1:0] rd_data,
    output stbs_stat_t                  stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          lo_reg;
    logic [CW-1:0]          hix_reg;     // one past the upper bound
    logic [AW-1:0]          mid_reg;
    logic [ENTRY_WIDTH-1:0] key_reg;
    logic                   found_reg;
    logic [POS_W-1:0]       pos_reg;

    logic [CW-1:0]          span;
    logic [CW-1:0]          probe_mid;
    logic                   range_empty;
    logic [31:0]            mid_ext;

    // Midpoint of the live range lo..hix-1
    always_comb
    begin
        span        = hix_reg - lo_reg - CW'(1);
        probe_mid   = lo_reg + (span >> 1);
        range_empty = (lo_reg >= hix_reg);
        mid_ext     = 32'(mid_reg);
    end

    // Issue a table read for each probe
    assign rd_en   = (state_reg == S_PROBE) && !range_empty;
    assign rd_addr = probe_mid[AW-1:0];

    // Sequence the search: probe, compare, narrow, report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lo_reg    <= '0;
            hix_reg   <= '0;
            mid_reg   <= '0;
            key_reg   <= '0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        lo_reg    <= '0;
                        hix_reg   <= limit;
                        key_reg   <= key;
                        state_reg <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (range_empty)
                    begin
                        found_reg <= 1'b0;
                        pos_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        mid_reg   <= probe_mid[AW-1:0];
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (rd_data == key_reg)
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= mid_ext[POS_W-1:0];
                        state_reg <= S_DONE;
                    end
                    else if (rd_data < key_reg)
                    begin
                        lo_reg    <= CW'(mid_reg) + CW'(1);
                        state_reg <= S_PROBE;
                    end
                    else
                    begin
                        hix_reg   <= CW'(mid_reg);
                        state_reg <= S_PROBE;
                    end
                end
                S_DONE:
                begin
                    if (take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Report status
    always_comb
    begin
        stat.idle     = (state_reg == S_IDLE);
        stat.done     = (state_reg == S_DONE);
        stat.found    = found_reg;
        stat.position = pos_reg;
    end

    // A compare always follows the probe that read the table
    a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(state_reg) == S_PROBE)
        else $error("compare without a preceding probe");

    // The probed index lies inside the live range
    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> (CW'(mid_reg) >= lo_reg && CW'(mid_reg) < hix_reg))
        else $error("probe index outside search range");

    // The range never inverts while probing
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> lo_reg <= hix_reg)
        else $error("search range inverted");

    // A search starts only on an idle sequencer
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("search started while busy");

endmodule

`default_nettype wire

// File: test/stbs_search_check_pkg.sv
// Result checking for the sorted-table binary search unit testbench: answer type and scoreboard.
// Depends on stbs_pkg for port widths, table depth and item opcodes.
`timescale 1ns / 1ps

package stbs_search_check_pkg;

    import stbs_pkg::*;

    // One search answer as the block reports it
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } search_answer_t;

    class search_checker;

        // Shadow of the table and the count register
        logic [VALUE_W-1:0] entries [DEF_TABLE_DEPTH];
        logic [COUNT_W-1:0] entries_in_use;

        // Answers still owed by the block, oldest first
        search_answer_t     owed_answers [$];

        int                 mismatches;
        int                 table_writes;
        int                 searches;
        int                 expected_hits;
        int                 count_writes;

        function new();
            entries_in_use = '0;
            mismatches     = 0;
            table_writes   = 0;
            searches       = 0;
            expected_hits  = 0;
            count_writes   = 0;
        endfunction

        function void set_count(logic [COUNT_W-1:0] count);
            entries_in_use = count;
            count_writes++;
        endfunction

        // Walk the halving probe path over the loaded range
        function search_answer_t predict_search(logic [VALUE_W-1:0] key);
            search_answer_t answer;
            int             lo;
            int             hi;
            int             mid;
            answer = '0;
            lo     = 0;
            hi     = int'(entries_in_use);
            if (hi > DEF_TABLE_DEPTH)
            begin
                hi = DEF_TABLE_DEPTH;
            end
            hi = hi - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (entries[mid] == key)
                begin
                    answer.hit = 1'b1;
                    answer.pos = POS_W'(mid);
                    break;
                end
                else if (entries[mid] < key)
                begin
                    lo = mid + 1;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
            return answer;
        endfunction

        // Apply an accepted input beat: store the entry or owe an answer
        function void note_beat(logic beat_mode, logic [INDEX_W-1:0] idx,
                                logic [VALUE_W-1:0] data);
            search_answer_t answer;
            if (beat_mode == MODE_WRITE)
            begin
                entries[idx] = data;
                table_writes++;
            end
            else
            begin
                answer = predict_search(data);
                owed_answers.push_back(answer);
                searches++;
                if (answer.hit)
                begin
                    expected_hits++;
                end
            end
        endfunction

        function int pending();
            return owed_answers.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Compare one accepted result beat with the oldest owed answer
        task check_result(logic got_found, logic [POS_W-1:0] got_pos);
            search_answer_t want;
            if (owed_answers.size() == 0)
            begin
                report_mismatch($sformatf("result found=%0b position=%0d with no search waiting",
                                          got_found, got_pos));
                return;
            end
            want = owed_answers.pop_front();
            if (got_found !== want.hit)
            begin
                report_mismatch($sformatf("found %0b, expected %0b", got_found, want.hit));
            end
            if (got_pos !== want.pos)
            begin
                report_mismatch($sformatf("position %0d, expected %0d", got_pos, want.pos));
            end
        endtask

    endclass

endpackage

// File: test/tb_sorted_table_binary_search_unit.sv
// Testbench top for the sorted-table binary search unit: clock, reset, beat drivers, phases.
// Depends on stbs_pkg, stbs_search_check_pkg and the RTL top sorted_table_binary_search_unit.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_unit;

    import stbs_pkg::*;
    import stbs_search_check_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0] cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               mode        = MODE_WRITE;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [VALUE_W-1:0] value       = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               found;
    logic [POS_W-1:0]   position;

    int                 send_idle_pct = 29;
    int                 recv_idle_pct = 87;
    int                 hold_requests = 0;

    search_checker      sb = new();

    sorted_table_binary_search_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .entry_index (entry_index),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .position    (position)
    );

    always #6 clk = ~clk;

    // Drive out_ready: random idling, or a long hold-off when one is requested
    initial
    begin : receiver
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(found, position);
        end
    end

    // End the run if it hangs
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sorted_table_binary_search_unit verification failed");
        $finish;
    end

    // Offer one input beat and hold it until accepted
    task automatic send_beat(logic beat_mode, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= beat_mode;
        entry_index <= idx;
        value       <= data;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_beat(beat_mode, idx, data);
    endtask

    // Stop offering, wait for every owed answer, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_count(count);
    endtask

    // Load positions 0..n-1 with a fresh ascending sequence
    task automatic load_sorted(int n, int unsigned step_max);
        logic [63:0] level;
        level = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(0, step_max));
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1 && $urandom_range(0, 2) == 0)
            begin
                level = 64'hFFFF_FFFF;
            end
            send_beat(MODE_WRITE, INDEX_W'(i), level[VALUE_W-1:0]);
            level = level + 64'($urandom_range(0, step_max));
            if (level > 64'hFFFF_FFFF)
            begin
                level = 64'hFFFF_FFFF;
            end
        end
    endtask

    // Mostly searches for present keys, some near misses and odd keys, a few stray writes
    task automatic send_mixed(int n);
        int unsigned        r;
        int unsigned        pick;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] key;
        r    = $urandom_range(0, 99);
        pick = (n > 0) ? $urandom_range(0, n - 1) : 0;
        if (r < 8)
        begin
            idx = INDEX_W'($urandom_range(0, DEF_TABLE_DEPTH - 1));
            if (r < 4 && idx < n)
            begin
                key = sb.entries[idx];
            end
            else
            begin
                key = $urandom();
            end
            send_beat(MODE_WRITE, idx, key);
            return;
        end
        if (n == 0 || r < 16)
        begin
            case ($urandom_range(0, 2))
                0:       key = '0;
                1:       key = '1;
                default: key = $urandom();
            endcase
        end
        else if (r < 34)
        begin
            key = (r[0]) ? sb.entries[pick] + 1'b1 : sb.entries[pick] - 1'b1;
        end
        else
        begin
            key = sb.entries[pick];
        end
        send_beat(MODE_SEARCH, INDEX_W'($urandom_range(0, DEF_TABLE_DEPTH - 1)), key);
    endtask

    // One setting of the count register, an optional sorted reload, then random traffic
    task automatic run_phase(logic [COUNT_W-1:0] count, bit reload, bit dense, int n_mixed,
                             int hold_at, int pause_at);
        int n;
        drain();
        write_count(count);
        n = (count > DEF_TABLE_DEPTH) ? DEF_TABLE_DEPTH : int'(count);
        if (reload && n > 0)
        begin
            load_sorted(n, dense ? 3 : 32'hFFFF_FFFF / n);
        end
        for (int k = 0; k < n_mixed; k++)
        begin
            if (k == hold_at)
            begin
                hold_requests++;
            end
            if (k == pause_at)
            begin
                drain();
            end
            send_mixed(n);
        end
    endtask

    initial
    begin : main
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table straight after reset
        send_beat(MODE_SEARCH, 8'hFF, 32'h0000_0000);
        send_beat(MODE_SEARCH, 8'h00, 32'hFFFF_FFFF);
        // Small table with a duplicate and both value extremes, plus the top index
        send_beat(MODE_WRITE, 8'd0, 32'h0000_0000);
        send_beat(MODE_WRITE, 8'd1, 32'h0000_0007);
        send_beat(MODE_WRITE, 8'd2, 32'h0000_0007);
        send_beat(MODE_WRITE, 8'd3, 32'hFFFF_FFFF);
        send_beat(MODE_WRITE, 8'hFF, 32'hA5A5_A5A5);
        drain();
        write_count(9'd1);
        send_beat(MODE_SEARCH, 8'h55, 32'h0000_0000);
        send_beat(MODE_SEARCH, 8'hAA, 32'h0000_0007);
        drain();
        write_count(9'd4);
        send_beat(MODE_SEARCH, 8'd0, 32'h0000_0000);
        send_beat(MODE_SEARCH, 8'd0, 32'h0000_0007);
        send_beat(MODE_SEARCH, 8'd0, 32'hFFFF_FFFF);
        send_beat(MODE_SEARCH, 8'd0, 32'h0000_0006);
        send_beat(MODE_SEARCH, 8'd0, 32'h0000_0008);
        // Break the order: a present key falls off the probe path
        send_beat(MODE_WRITE, 8'd2, 32'h0000_0001);
        send_beat(MODE_SEARCH, 8'd0, 32'h0000_0001);
        send_beat(MODE_SEARCH, 8'd0, 32'h0000_0007);

        // Sender idles lightly, receiver heavily
        run_phase(9'd256, 1'b1, 1'b0, 180, 20, -1);
        run_phase(9'h1FF, 1'b0, 1'b0, 150, -1, -1);

        // Sender idles heavily, receiver lightly
        send_idle_pct = 87;
        recv_idle_pct = 29;
        run_phase(COUNT_W'($urandom_range(1, 31)), 1'b1, 1'b1, 150, -1, 75);
        run_phase(9'd255, 1'b1, 1'b0, 150, -1, -1);
        run_phase(COUNT_W'($urandom_range(1, 8)), 1'b1, 1'b0, 120, -1, -1);

        // No idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(9'd300, 1'b0, 1'b0, 150, 30, -1);
        run_phase(9'd0, 1'b0, 1'b0, 30, -1, -1);
        run_phase(COUNT_W'($urandom_range(9, 64)), 1'b1, 1'b1, 170, -1, -1);

        drain();
        $display("Covered %0d table writes and %0d searches (%0d expected hits) over %0d counts.",
                 sb.table_writes, sb.searches, sb.expected_hits, sb.count_writes);
        $display("Traffic ran sender-starved, receiver-starved and back-to-back, with hold-offs.");
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("sorted_table_binary_search_unit verification clean");
        end
        else
        begin
            $display("sorted_table_binary_search_unit verification failed");
        end
        $finish;
    end

endmodule

// File: sorted_table_binary_search_unit.f
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_seq.sv
src/sorted_table_binary_search_unit.sv
test/stbs_search_check_pkg.sv
test/tb_sorted_table_binary_search_unit.sv
